>>> hdl/swmc_pkg.sv
// Shared types, constants and letter classification for the Soundex word match counter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package swmc_pkg;

   // Field widths.
   localparam int CharWidth   = 8;
   localparam int LetterWidth = 7;
   localparam int DigitsWidth = 9;
   localparam int DigitWidth  = 3;
   localparam int FillWidth   = 2;
   localparam int RspWidth    = 16;
   localparam int CsrIdxWidth = 1;
   localparam int CsrDataWidth = 9;

   // Default width of the internal match counter.
   localparam int DefaultCountWidth = 16;

   // Reset value of the target letter ('A').
   localparam logic [LetterWidth-1:0] TargetLetterReset = 7'h41;

   // Configuration register indexes.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TARGET_LETTER = 1'b0,
      CSR_TARGET_DIGITS = 1'b1
   } csr_index_type;

   // One input beat as held in the input register.
   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 last_char;
   } char_beat_type;

   // Target code as written by software.
   typedef struct packed {
      logic [LetterWidth-1:0] letter;
      logic [DigitsWidth-1:0] digits;
   } target_type;

   // Upper-case a byte; anything that is not a lower-case letter passes unchanged.
   function automatic logic [CharWidth-1:0] to_upper(input logic [CharWidth-1:0] c);
      if (c >= "a" && c <= "z") begin
         return c - 8'd32;
      end
      return c;
   endfunction

   // True for A-Z and a-z.
   function automatic logic is_letter(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] u;
      u = to_upper(c);
      return (u >= "A" && u <= "Z");
   endfunction

   // Soundex digit of an upper-case letter; 0 for the vowels and H, W, Y.
   function automatic logic [DigitWidth-1:0] digit_of(input logic [CharWidth-1:0] u);
      logic [DigitWidth-1:0] d;
      unique case (u)
         "B", "F", "P", "V":                     d = 3'd1;
         "C", "G", "J", "K", "Q", "S", "X", "Z": d = 3'd2;
         "D", "T":                               d = 3'd3;
         "L":                                    d = 3'd4;
         "M", "N":                               d = 3'd5;
         "R":                                    d = 3'd6;
         default:                                d = 3'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> hdl/soundex_word_match_counter_core.sv
// A beat waits in the input register; its count result is then held in the result register.
// Throughput: one character per cycle unless a last beat meets a full result register;
// the two registers let a new beat enter while an earlier result still waits to be taken.
// Reset (synchronous, active high) clears the word state, the count and both valid
// flags, and sets the target code to the letter A with no digits.
`default_nettype none

module soundex_word_match_counter_core #(
   parameter int CountWidth = swmc_pkg::DefaultCountWidth
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Character channel.
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [swmc_pkg::CharWidth-1:0]   req_char_code,
   input  wire logic                             req_last_char,
   // Result channel.
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [swmc_pkg::RspWidth-1:0]         rsp_match_count,
   // Configuration channel.
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [swmc_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [swmc_pkg::CsrDataWidth-1:0] csr_data
);
   import swmc_pkg::*;

   target_type    target_ff;
   logic          in_valid_ff;
   char_beat_type in_beat_ff;
   logic          step;
   logic          word_hit;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff.letter <= TargetLetterReset;
         target_ff.digits <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_LETTER: target_ff.letter <= csr_data[LetterWidth-1:0];
            CSR_TARGET_DIGITS: target_ff.digits <= csr_data[DigitsWidth-1:0];
            default:           target_ff <= target_ff;
         endcase
      end
   end

   // The held beat moves on unless it needs the result register and that is still full.
   assign step      = in_valid_ff && (!in_beat_ff.last_char || !rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_beat_ff.char_code <= req_char_code;
         in_beat_ff.last_char <= req_last_char;
      end
   end

   swmc_word_coder u_word_coder (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .beat     (in_beat_ff),
      .target   (target_ff),
      .word_hit (word_hit)
   );

   swmc_match_counter #(
      .CountWidth (CountWidth)
   ) u_match_counter (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .last_char       (in_beat_ff.last_char),
      .word_hit        (word_hit),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_match_count (rsp_match_count)
   );

endmodule

`default_nettype wire

>>> hdl/swmc_word_coder.sv
// Per-word Soundex coder: tracks the open word, builds its code and flags a target hit.
// Depends on swmc_pkg.
`default_nettype none

module swmc_word_coder (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire swmc_pkg::char_beat_type beat,
   input  wire swmc_pkg::target_type    target,
   output logic                        word_hit
);
   import swmc_pkg::*;

   logic                   in_word_ff, in_word_in;
   logic [LetterWidth-1:0] first_letter_ff, first_letter_in;
   logic [DigitsWidth-1:0] code_digits_ff, code_digits_in;
   logic [FillWidth-1:0]   fill_level_ff, fill_level_in;
   logic                   repeat_ok_ff, repeat_ok_in;

   logic [CharWidth-1:0]  upper;
   logic                  letter;
   logic [DigitWidth-1:0] digit;
   logic [DigitWidth-1:0] prev_digit;
   logic                  closing;
   logic                  word_open;

   assign upper  = to_upper(beat.char_code);
   assign letter = is_letter(beat.char_code);
   assign digit  = digit_of(upper);

   // Last kept digit; only looked at once at least one digit is kept.
   always_comb begin
      unique case (fill_level_ff)
         2'd1:    prev_digit = code_digits_ff[8:6];
         2'd2:    prev_digit = code_digits_ff[5:3];
         default: prev_digit = code_digits_ff[2:0];
      endcase
   end

   // Next word state for this beat.
   always_comb begin
      in_word_in      = in_word_ff;
      first_letter_in = first_letter_ff;
      code_digits_in  = code_digits_ff;
      fill_level_in   = fill_level_ff;
      repeat_ok_in    = repeat_ok_ff;
      if (letter && !in_word_ff) begin
         in_word_in      = 1'b1;
         first_letter_in = upper[LetterWidth-1:0];
         code_digits_in  = '0;
         fill_level_in   = '0;
         repeat_ok_in    = 1'b0;
      end else if (letter && fill_level_ff != 2'd3) begin
         if (digit == '0) begin
            repeat_ok_in = 1'b1;
         end else if (!(fill_level_ff != '0 && digit == prev_digit && !repeat_ok_ff)) begin
            unique case (fill_level_ff)
               2'd0:    code_digits_in[8:6] = digit;
               2'd1:    code_digits_in[5:3] = digit;
               default: code_digits_in[2:0] = digit;
            endcase
            fill_level_in = fill_level_ff + 2'd1;
            repeat_ok_in  = 1'b0;
         end
      end
      // A separator or the final beat closes the word after this beat's letter.
      closing   = !letter || beat.last_char;
      word_open = in_word_in;
      if (closing) begin
         in_word_in = 1'b0;
      end
   end

   // Compare the closing word with the target code.
   assign word_hit = step && closing && word_open
                   && first_letter_in == target.letter
                   && code_digits_in == target.digits;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff      <= 1'b0;
         first_letter_ff <= '0;
         code_digits_ff  <= '0;
         fill_level_ff   <= '0;
         repeat_ok_ff    <= 1'b1;
      end else if (step) begin
         in_word_ff      <= in_word_in;
         first_letter_ff <= first_letter_in;
         code_digits_ff  <= code_digits_in;
         fill_level_ff   <= fill_level_in;
         repeat_ok_ff    <= repeat_ok_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/swmc_match_counter.sv
// Saturating match counter and result register for one sentence.
// Depends on swmc_pkg.
`default_nettype none

module swmc_match_counter #(
   parameter int CountWidth = swmc_pkg::DefaultCountWidth
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic                          last_char,
   input  wire logic                          word_hit,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [swmc_pkg::RspWidth-1:0]      rsp_match_count
);
   import swmc_pkg::*;

   localparam int ExtWidth = (CountWidth > RspWidth) ? CountWidth : RspWidth;

   logic [CountWidth-1:0] matches_ff, matches_in;
   logic [ExtWidth-1:0]   matches_ext;
   logic                  rsp_valid_ff;
   logic [RspWidth-1:0]   rsp_count_ff, rsp_count_in;

   // Count a hit unless the counter is already full.
   always_comb begin
      matches_in = matches_ff;
      if (word_hit && matches_ff != {CountWidth{1'b1}}) begin
         matches_in = matches_ff + CountWidth'(1);
      end
   end

   // Saturate the count to the result width.
   assign matches_ext  = ExtWidth'(matches_in);
   assign rsp_count_in = (matches_ext > ExtWidth'({RspWidth{1'b1}}))
                       ? {RspWidth{1'b1}} : matches_ext[RspWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         matches_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            matches_ff <= last_char ? '0 : matches_in;
         end
         if (step && last_char) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (step && last_char) begin
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;

endmodule

`default_nettype wire
